FILE: hw/rtl/dmc_pkg.sv
// dmc_pkg: shared types and constants for the direct-mapped cache lookup
// used by dmc_mod and direct_mapped_cache_lookup, no dependencies
package dmc_pkg;

  localparam int unsigned CountWidth    = 9;
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned IndexOutWidth = 8;

  localparam logic [CountWidth-1:0] LineCountReset = 9'd256;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StDiv,
    StLook
  } dmc_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic                  last;
    logic [CountWidth-1:0] rem;
  } dmc_div_t;

endpackage

FILE: hw/rtl/direct_mapped_cache_lookup.sv
// direct_mapped_cache_lookup: one word per line, index = address mod line count
// a request is accepted only in idle; the bit-serial remainder unit then computes the index,
//   the line memory is read, and on a miss the line is updated, and the result is registered once the
//   output can advance; no new request is taken until then
// reset: line count 256, then a clearing pass over every line memory entry during
//   which no request is taken
module direct_mapped_cache_lookup import dmc_pkg::*; #(
  parameter int unsigned MAX_LINES    = 256,
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CountWidth-1:0]       cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ADDRESS_BITS-1:0]     word_address_i,
  input  logic signed [WordWidth-1:0] fill_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic                        displaced_o,
  output logic [IndexOutWidth-1:0]    line_index_o,
  output logic signed [WordWidth-1:0] read_word_o
);

  // line count is at most 511, so no index beyond that is ever used
  localparam int unsigned Depth = (MAX_LINES > 512) ? 512 : MAX_LINES;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntW  = 1 + ADDRESS_BITS + WordWidth;

  dmc_state_e state_q, state_d;

  logic [CountWidth-1:0]     line_count_q;
  logic [CountWidth-1:0]     divisor;
  logic [ADDRESS_BITS-1:0]   req_addr_q;
  logic [WordWidth-1:0]      req_word_q;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           clr_q, clr_d;
  logic                      in_acc;
  logic                      div_step;
  dmc_div_t                  div_st;

  logic [EntW-1:0]           mem [Depth];
  logic [EntW-1:0]           rd_q;
  logic                      mem_re;
  logic [IdxW-1:0]           mem_raddr;
  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  logic [EntW-1:0]           mem_wdata;

  logic                      ent_valid;
  logic [ADDRESS_BITS-1:0]   ent_tag;
  logic [WordWidth-1:0]      ent_data;
  logic                      hit;
  logic                      advance;

  logic                      out_valid_q, out_valid_d;
  logic                      hit_q, disp_q;
  logic [IndexOutWidth-1:0]  index_q;
  logic [WordWidth-1:0]      word_q;

  // effective line count: zero means one line, clamp at the line capacity
  always_comb begin
    divisor = line_count_q;
    if (line_count_q == '0) begin
      divisor = CountWidth'(1);
    end
    if (32'(divisor) > 32'(MAX_LINES)) begin
      divisor = CountWidth'(MAX_LINES);
    end
  end

  assign in_acc = in_valid_i && in_ready_o;

  dmc_mod #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .step_i    (div_step),
    .dividend_i(word_address_i),
    .divisor_i (divisor),
    .status_o  (div_st)
  );

  assign {ent_valid, ent_tag, ent_data} = rd_q;
  assign hit     = ent_valid && (ent_tag == req_addr_q);
  assign advance = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_step   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = div_st.rem[IdxW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = {1'b1, req_addr_q, req_word_q};
    idx_d      = idx_q;
    clr_d      = clr_q;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdxW'(Depth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        div_step = 1'b1;
        if (div_st.last) begin
          // final remainder goes straight to the memory read port
          mem_re  = 1'b1;
          idx_d   = div_st.rem[IdxW-1:0];
          state_d = StLook;
        end
      end
      StLook: begin
        if (advance) begin
          mem_we  = !hit;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == StLook && advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      line_count_q <= LineCountReset;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        line_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (in_acc) begin
      req_addr_q <= word_address_i;
      req_word_q <= fill_word_i;
    end
    if (state_q == StLook && advance) begin
      hit_q   <= hit;
      disp_q  <= !hit && ent_valid;
      index_q <= IndexOutWidth'(idx_q);
      word_q  <= hit ? ent_data : req_word_q;
    end
  end

  // line memory: valid, tag and data in one word
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign displaced_o  = disp_q;
  assign line_index_o = index_q;
  assign read_word_o  = word_q;

endmodule

FILE: hw/rtl/dmc_mod.sv
// dmc_mod: restoring remainder unit, one address bit per cycle while step_i is high
// depends on dmc_pkg
module dmc_mod import dmc_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [ADDRESS_BITS-1:0] dividend_i,
  input  logic [CountWidth-1:0]   divisor_i,
  output dmc_div_t                status_o
);

  localparam int unsigned CntW = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;

  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [CountWidth-1:0]   rem_q, rem_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CountWidth:0]     shifted;

  always_comb begin
    // bring down the next address bit, subtract if it fits
    shifted = {rem_q, addr_q[ADDRESS_BITS-1]};
    if (shifted >= {1'b0, divisor_i}) begin
      rem_d = CountWidth'(shifted - {1'b0, divisor_i});
    end else begin
      rem_d = shifted[CountWidth-1:0];
    end
  end

  always_comb begin
    addr_d = addr_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      addr_d = dividend_i;
      cnt_d  = '0;
    end else if (step_i) begin
      addr_d = addr_q << 1;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (start_i) begin
        rem_q <= '0;
      end else if (step_i) begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  assign status_o.last = (cnt_q == CntW'(ADDRESS_BITS - 1));
  assign status_o.rem  = rem_d;

endmodule

FILE: bench/testbench.sv
// testbench for direct_mapped_cache_lookup: directed table, then random request traffic
// checked against an in-bench line model; depends on dmc_pkg and the cache rtl
`timescale 1ns / 1ps

module testbench;
  import dmc_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic                 displaced;
    logic [IndexOutWidth-1:0] line_index;
    logic [WordWidth-1:0] read_word;
  } lookup_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CountWidth-1:0] count;
    logic [15:0]          addr;
    logic [WordWidth-1:0] word;
    bit                   typed;
    lookup_result_t       res;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CountWidth-1:0]       cfg_wdata = '0;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic [15:0]                 req_addr = '0;
  logic signed [WordWidth-1:0] req_fill = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic                        rsp_hit;
  logic                        rsp_displaced;
  logic [IndexOutWidth-1:0]    rsp_index;
  logic signed [WordWidth-1:0] rsp_word;

  // shadow copy of the cache lines and the line count register
  bit                   shadow_valid [256];
  logic [15:0]          shadow_tag   [256];
  logic [WordWidth-1:0] shadow_data  [256];
  logic [CountWidth-1:0] cur_line_count = LineCountReset;

  lookup_result_t pending_lookups[$];
  stim_row_t      directed_rows[$];
  logic [15:0]    hot_addrs [12];
  int             mismatches = 0;
  int             results_seen = 0;
  int             hold_left = 0;
  bit             long_hold_done = 1'b0;
  bit             sender_quiet = 1'b0;

  direct_mapped_cache_lookup dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .word_address_i (req_addr),
    .fill_word_i    (req_fill),
    .out_valid_o    (rsp_valid),
    .out_ready_i    (rsp_ready),
    .hit_o          (rsp_hit),
    .displaced_o    (rsp_displaced),
    .line_index_o   (rsp_index),
    .read_word_o    (rsp_word)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  initial begin
    #8000000;
    $display("direct_mapped_cache_lookup test failed");
    $finish;
  end

  function automatic lookup_result_t lookup_line(input logic [15:0] addr,
                                                 input logic [WordWidth-1:0] word);
    lookup_result_t r;
    int unsigned    lines;
    int unsigned    idx;
    lines = cur_line_count;
    if (lines == 0) lines = 1;
    if (lines > 256) lines = 256;
    idx = addr % lines;
    r.line_index = idx[7:0];
    if (shadow_valid[idx] && shadow_tag[idx] == addr) begin
      r.hit       = 1'b1;
      r.displaced = 1'b0;
      r.read_word = shadow_data[idx];
    end else begin
      r.hit             = 1'b0;
      r.displaced       = shadow_valid[idx];
      shadow_valid[idx] = 1'b1;
      shadow_tag[idx]   = addr;
      shadow_data[idx]  = word;
      r.read_word       = word;
    end
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return hot_addrs[$urandom_range(0, 11)];
    if (r < 8) return 16'($urandom_range(0, 600));
    return 16'($urandom);
  endfunction

  function automatic logic [WordWidth-1:0] pick_fill();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void cfg_row(input logic [CountWidth-1:0] count);
    stim_row_t row;
    row = '{1'b1, count, 16'h0, 32'h0, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void req_row(input logic [15:0] addr, input logic [31:0] word);
    stim_row_t row;
    row = '{1'b0, '0, addr, word, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void typed_row(input logic [15:0] addr, input logic [31:0] word,
                                    input logic hit, input logic disp,
                                    input logic [7:0] idx, input logic [31:0] rword);
    stim_row_t row;
    row = '{1'b0, '0, addr, word, 1'b1, '{hit, disp, idx, rword}};
    directed_rows.push_back(row);
  endfunction

  // request stays valid from the previous call unless a gap is taken
  task automatic send_request(input logic [15:0] addr, input logic [WordWidth-1:0] word,
                              input int gap, input bit typed, input lookup_result_t typed_res);
    lookup_result_t pred;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_addr  <= addr;
    req_fill  <= word;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    pred = lookup_line(addr, word);
    pending_lookups.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_line_count(input logic [CountWidth-1:0] count);
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0 || !req_ready) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we         <= 1'b0;
    cur_line_count  = count;
  endtask

  // response side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_n) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_lookups.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp_hit));
          check_field("displaced", 32'(want.displaced), 32'(rsp_displaced));
          check_field("line_index", 32'(want.line_index), 32'(rsp_index));
          check_field("read_word", want.read_word, rsp_word);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        hold_left      = 500;
        rsp_ready     <= 1'b0;
      end else if ((results_seen % 400) >= 300 || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
      end else begin
        hold_left  = pick_gap(1'b0);
        rsp_ready <= 1'b0;
      end
    end
  end

  initial begin
    logic [CountWidth-1:0] count;
    stim_row_t row;

    // line count starts at 256
    typed_row(16'h0000, 32'h7fff_ffff, 1'b0, 1'b0, 8'd0,   32'h7fff_ffff);
    typed_row(16'h0000, 32'h0000_0000, 1'b1, 1'b0, 8'd0,   32'h7fff_ffff);
    typed_row(16'h0100, 32'h8000_0000, 1'b0, 1'b1, 8'd0,   32'h8000_0000);
    typed_row(16'hffff, 32'hffff_ffff, 1'b0, 1'b0, 8'd255, 32'hffff_ffff);
    typed_row(16'hffff, 32'h1234_5678, 1'b1, 1'b0, 8'd255, 32'hffff_ffff);
    typed_row(16'h00ff, 32'ha5a5_a5a5, 1'b0, 1'b1, 8'd255, 32'ha5a5_a5a5);
    req_row(16'h5555, 32'h5555_aaaa);
    req_row(16'haaaa, 32'haaaa_5555);
    req_row(16'h0100, 32'h0000_0000);
    // zero count acts as a single line
    cfg_row(9'd0);
    typed_row(16'h1234, 32'h0123_4567, 1'b0, 1'b1, 8'd0, 32'h0123_4567);
    typed_row(16'h1234, 32'hdead_beef, 1'b1, 1'b0, 8'd0, 32'h0123_4567);
    req_row(16'h4321, 32'h7654_3210);
    // counts above the line total saturate
    cfg_row(9'd511);
    req_row(16'hffff, 32'h0bad_f00d);
    req_row(16'h4321, 32'h1111_1111);
    cfg_row(9'd257);
    req_row(16'h0101, 32'h2222_2222);
    // lines survive a count change
    cfg_row(9'd1);
    req_row(16'h4321, 32'h3333_3333);
    cfg_row(9'd256);
    req_row(16'hffff, 32'h4444_4444);
    req_row(16'h4321, 32'h5555_5555);
    cfg_row(9'd255);
    req_row(16'hffff, 32'h0000_0000);
    req_row(16'h00fe, 32'h6666_6666);
    cfg_row(9'd2);
    req_row(16'h8001, 32'h7777_7777);
    req_row(16'h7ffe, 32'h8888_8888);

    wait (rst_n);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) write_line_count(row.count);
      else send_request(row.addr, row.word, pick_gap(1'b0), row.typed, row.res);
    end

    for (int p = 0; p < 14; p++) begin
      case (p)
        0: count = 9'd1;
        1: count = 9'd256;
        2: count = 9'd0;
        3: count = 9'd511;
        4: count = 9'd2;
        5: count = 9'd257;
        6: count = 9'd255;
        default: count = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(1, 16))
                                                      : 9'($urandom_range(0, 511));
      endcase
      write_line_count(count);
      foreach (hot_addrs[k])
        hot_addrs[k] = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      sender_quiet = (p % 4 == 3);
      for (int i = 0; i < 125; i++)
        send_request(pick_addr(), pick_fill(), pick_gap(sender_quiet), 1'b0, '0);
    end

    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_lookups.size() == 0)
      $display("direct_mapped_cache_lookup test passed");
    else
      $display("direct_mapped_cache_lookup test failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_mod.sv
hw/rtl/direct_mapped_cache_lookup.sv
bench/testbench.sv
